[rtl/ofoc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofoc_pkg
// Shared types, widths and codes for the offset-free observer/controller.
// ----------------------------------------------------------------------------
package ofoc_pkg;

  // Datapath widths: signed Q16.16 words, 64-bit accumulation.
  localparam int DATA_W = 32;
  localparam int ACC_W  = 64;
  localparam int FRAC_W = 16;

  // Input word field widths.
  localparam int REQ_W  = 2;
  localparam int SEL_W  = 4;
  localparam int IDX_W  = 4;
  localparam int CIDX_W = 2;

  // Coefficient store: ten matrices of 16 by 16 entries.
  localparam int MAT_COUNT  = 10;
  localparam int COEF_DEPTH = MAT_COUNT * (2 ** (2 * IDX_W));
  localparam int COEF_AW    = $clog2(COEF_DEPTH);

  // Configuration register widths and the APB address width.
  localparam int STATES_W  = 4;
  localparam int CONTROL_W = 3;
  localparam int MEAS_W    = 4;
  localparam int DIST_W    = 3;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // Request kinds.
  typedef enum logic [REQ_W-1:0] {
    REQ_COEF     = 2'd0,
    REQ_SETPOINT = 2'd1,
    REQ_MEAS     = 2'd2
  } req_type_e;

  // Matrix selectors.
  localparam logic [SEL_W-1:0] MAT_A    = 4'd0;
  localparam logic [SEL_W-1:0] MAT_B    = 4'd1;
  localparam logic [SEL_W-1:0] MAT_C    = 4'd2;
  localparam logic [SEL_W-1:0] MAT_BD   = 4'd3;
  localparam logic [SEL_W-1:0] MAT_CD   = 4'd4;
  localparam logic [SEL_W-1:0] MAT_LX   = 4'd5;
  localparam logic [SEL_W-1:0] MAT_LD   = 4'd6;
  localparam logic [SEL_W-1:0] MAT_H    = 4'd7;
  localparam logic [SEL_W-1:0] MAT_GINV = 4'd8;
  localparam logic [SEL_W-1:0] MAT_G    = 4'd9;

  // Configuration register indexes (word address bits).
  localparam logic [1:0] CFG_STATES   = 2'd0;
  localparam logic [1:0] CFG_CONTROLS = 2'd1;
  localparam logic [1:0] CFG_MEAS     = 2'd2;
  localparam logic [1:0] CFG_DIST     = 2'd3;

  // Index width for an array of n entries, never below one bit.
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

[rtl/ofoc_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofoc_req_if
// Request channel: coefficient, setpoint and measurement words.
// ----------------------------------------------------------------------------
interface ofoc_req_if import ofoc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [SEL_W-1:0]         matrix_sel;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [DATA_W-1:0] data_value;
  logic                     sample_last;

  modport source (
    output valid, req_type, matrix_sel, row_index, col_index, data_value, sample_last,
    input  ready
  );
  modport sink (
    input  valid, req_type, matrix_sel, row_index, col_index, data_value, sample_last,
    output ready
  );
endinterface

// ----------------------------------------------------------------------------
// ofoc_rsp_if
// Result channel: one control element per word.
// ----------------------------------------------------------------------------
interface ofoc_rsp_if import ofoc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CIDX_W-1:0]        control_index;
  logic signed [DATA_W-1:0] control_value;
  logic                     saturated;
  logic                     run_last;

  modport source (
    output valid, control_index, control_value, saturated, run_last,
    input  ready
  );
  modport sink (
    input  valid, control_index, control_value, saturated, run_last,
    output ready
  );
endinterface

[rtl/offset_free_observer_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// offset_free_observer_controller
// Offset-free observer with steady-state target selector and state feedback.
// ----------------------------------------------------------------------------
// Coefficient, setpoint and non-final measurement words are accepted
// whenever the block is idle. A measurement word marked last starts the
// control step, which runs every sum through one shared 32x32
// multiply-accumulate unit: for each output row the sequencer loads the
// leading term, issues the products segment by segment, drains the
// pipeline and writes the row back, and this repeats over ten phases.
// The block is not ready during the step; it then offers the control
// words one per cycle while the receiver is ready and returns to
// accepting requests after the last one is taken. The coefficient store
// is a RAM with one write port and a registered read port.
module offset_free_observer_controller import ofoc_pkg::*; #(
  parameter int MAX_STATES       = 8,
  parameter int MAX_CONTROLS     = 4,
  parameter int MAX_MEASUREMENTS = 8,
  parameter int MAX_DISTURBANCES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ofoc_req_if.sink           req,
  ofoc_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int N     = MAX_STATES + MAX_CONTROLS;
  localparam int NM    = (N > MAX_MEASUREMENTS) ? N : MAX_MEASUREMENTS;
  localparam int CNT_N = (NM > MAX_DISTURBANCES + 1) ? NM : MAX_DISTURBANCES + 1;
  localparam int CW    = $clog2(CNT_N + 1);
  localparam int XIW   = idx_w(MAX_STATES);
  localparam int UIW   = idx_w(MAX_CONTROLS);
  localparam int MIW   = idx_w(MAX_MEASUREMENTS);
  localparam int DIW   = idx_w(MAX_DISTURBANCES + 1);
  localparam int NIW   = idx_w(N);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LEAD  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // Step phases, one per vector that is computed.
  localparam logic [3:0] P_E   = 4'd0;
  localparam logic [3:0] P_XH  = 4'd1;
  localparam logic [3:0] P_DH  = 4'd2;
  localparam logic [3:0] P_PK  = 4'd3;
  localparam logic [3:0] P_CDD = 4'd4;
  localparam logic [3:0] P_PU  = 4'd5;
  localparam logic [3:0] P_R   = 4'd6;
  localparam logic [3:0] P_D   = 4'd7;
  localparam logic [3:0] P_U   = 4'd8;
  localparam logic [3:0] P_X   = 4'd9;

  localparam logic [1:0] SEG_LAST = 2'd2;

  // Control registers.
  logic [2:0]            state_q;
  logic [3:0]            phase_q;
  logic [1:0]            seg_q;
  logic [CW-1:0]         i_q, j_q, k_q;
  logic                  v1_q, v2_q, sat_q;
  logic [STATES_W-1:0]   state_count_q;
  logic [CONTROL_W-1:0]  control_count_q;
  logic [MEAS_W-1:0]     meas_count_q;
  logic [DIST_W-1:0]     dist_count_q;

  // Vectors held between steps and working vectors of one step.
  logic signed [DATA_W-1:0] xm_q   [MAX_STATES];
  logic signed [DATA_W-1:0] dm_q   [MAX_DISTURBANCES + 1];
  logic signed [DATA_W-1:0] sp_q   [MAX_CONTROLS];
  logic signed [DATA_W-1:0] meas_q [MAX_MEASUREMENTS];
  logic signed [DATA_W-1:0] e_q    [MAX_MEASUREMENTS];
  logic signed [DATA_W-1:0] cdd_q  [MAX_MEASUREMENTS];
  logic signed [DATA_W-1:0] xh_q   [MAX_STATES];
  logic signed [DATA_W-1:0] dh_q   [MAX_DISTURBANCES + 1];
  logic signed [DATA_W-1:0] pack_q [N];
  logic signed [DATA_W-1:0] r_q    [N];
  logic signed [DATA_W-1:0] dv_q   [MAX_STATES];
  logic signed [DATA_W-1:0] u_q    [MAX_CONTROLS];

  // Coefficient RAM and the multiply-accumulate pipeline.
  logic signed [DATA_W-1:0] coef_mem [COEF_DEPTH];
  logic signed [DATA_W-1:0] coef_rd_q, op_q;
  logic signed [ACC_W-1:0]  prod_q, acc_q;

  // Combinational signals.
  logic [CW-1:0]            nx, nu, ny, nd, n, rows, seg_len;
  logic [SEL_W-1:0]         seg_mat;
  logic signed [DATA_W-1:0] seg_op;
  logic signed [ACC_W-1:0]  lead, term;
  logic signed [DATA_W-1:0] s32;
  logic                     sat_hi, sat_lo, sub_mode, accept;
  logic [COEF_AW-1:0]       rd_addr, wr_addr;
  logic [NIW-1:0]           r_idx, pk_wr_idx;

  // Clamped sizes in use.
  always_comb begin
    if (state_count_q < STATES_W'(1))                nx = CW'(1);
    else if (state_count_q > STATES_W'(MAX_STATES))  nx = CW'(MAX_STATES);
    else                                             nx = CW'(state_count_q);
    if (control_count_q < CONTROL_W'(1))                 nu = CW'(1);
    else if (control_count_q > CONTROL_W'(MAX_CONTROLS)) nu = CW'(MAX_CONTROLS);
    else                                                 nu = CW'(control_count_q);
    if (meas_count_q < MEAS_W'(1))                     ny = CW'(1);
    else if (meas_count_q > MEAS_W'(MAX_MEASUREMENTS)) ny = CW'(MAX_MEASUREMENTS);
    else                                               ny = CW'(meas_count_q);
    if (dist_count_q > DIST_W'(MAX_DISTURBANCES)) nd = CW'(MAX_DISTURBANCES);
    else                                          nd = CW'(dist_count_q);
    n = nx + nu;
  end

  // Row count of each phase.
  always_comb begin
    case (phase_q)
      P_E:     rows = ny;
      P_XH:    rows = nx;
      P_DH:    rows = nd;
      P_PK:    rows = nx;
      P_CDD:   rows = ny;
      P_PU:    rows = nu;
      P_R:     rows = n;
      P_D:     rows = nx;
      P_U:     rows = nu;
      P_X:     rows = nx;
      default: rows = '0;
    endcase
  end

  // Product segments of a row: matrix, length and operand vector.
  always_comb begin
    seg_mat = MAT_A;
    seg_len = '0;
    seg_op  = '0;
    case (phase_q)
      P_E: begin
        if (seg_q == 2'd0) begin
          seg_mat = MAT_C;  seg_len = nx; seg_op = xm_q[j_q[XIW-1:0]];
        end else if (seg_q == 2'd1) begin
          seg_mat = MAT_CD; seg_len = nd; seg_op = dm_q[j_q[DIW-1:0]];
        end
      end
      P_XH: begin
        if (seg_q == 2'd0) begin
          seg_mat = MAT_LX; seg_len = ny; seg_op = e_q[j_q[MIW-1:0]];
        end
      end
      P_DH: begin
        if (seg_q == 2'd0) begin
          seg_mat = MAT_LD; seg_len = ny; seg_op = e_q[j_q[MIW-1:0]];
        end
      end
      P_PK: begin
        if (seg_q == 2'd0) begin
          seg_mat = MAT_BD; seg_len = nd; seg_op = dh_q[j_q[DIW-1:0]];
        end
      end
      P_CDD: begin
        if (seg_q == 2'd0) begin
          seg_mat = MAT_CD; seg_len = nd; seg_op = dh_q[j_q[DIW-1:0]];
        end
      end
      P_PU: begin
        if (seg_q == 2'd0) begin
          seg_mat = MAT_H; seg_len = ny; seg_op = cdd_q[j_q[MIW-1:0]];
        end
      end
      P_R: begin
        if (seg_q == 2'd0) begin
          seg_mat = MAT_GINV; seg_len = n; seg_op = pack_q[j_q[NIW-1:0]];
        end
      end
      P_U: begin
        if (seg_q == 2'd0) begin
          seg_mat = MAT_G; seg_len = nx; seg_op = dv_q[j_q[XIW-1:0]];
        end
      end
      P_X: begin
        if (seg_q == 2'd0) begin
          seg_mat = MAT_A;  seg_len = nx; seg_op = xh_q[j_q[XIW-1:0]];
        end else if (seg_q == 2'd1) begin
          seg_mat = MAT_B;  seg_len = nu; seg_op = u_q[j_q[UIW-1:0]];
        end else if (seg_q == 2'd2) begin
          seg_mat = MAT_BD; seg_len = nd; seg_op = dh_q[j_q[DIW-1:0]];
        end
      end
      default: begin
        seg_len = '0;
      end
    endcase
  end

  // Leading term of a row and the sign of its products.
  always_comb begin
    r_idx     = (phase_q == P_U) ? NIW'(nx + i_q) : i_q[NIW-1:0];
    pk_wr_idx = (phase_q == P_PU) ? NIW'(nx + i_q) : i_q[NIW-1:0];
    sub_mode  = (phase_q == P_E) || (phase_q == P_PU) || (phase_q == P_U);
    case (phase_q)
      P_E:     lead = ACC_W'(meas_q[i_q[MIW-1:0]]);
      P_XH:    lead = ACC_W'(xm_q[i_q[XIW-1:0]]);
      P_DH:    lead = ACC_W'(dm_q[i_q[DIW-1:0]]);
      P_PU:    lead = ACC_W'(sp_q[i_q[UIW-1:0]]);
      P_D:     lead = ACC_W'(xh_q[i_q[XIW-1:0]]) - ACC_W'(r_q[r_idx]);
      P_U:     lead = ACC_W'(r_q[r_idx]);
      default: lead = '0;
    endcase
  end

  // Product scaling (floor shift) and 32-bit saturation of the sum.
  assign term   = prod_q >>> FRAC_W;
  assign sat_hi = acc_q > ACC_W'(64'sh7FFF_FFFF);
  assign sat_lo = acc_q < -ACC_W'(64'sh8000_0000);
  always_comb begin
    if (sat_hi)      s32 = 32'sh7FFF_FFFF;
    else if (sat_lo) s32 = 32'sh8000_0000;
    else             s32 = acc_q[DATA_W-1:0];
  end

  assign rd_addr = {seg_mat, IDX_W'(i_q), IDX_W'(j_q)};
  assign wr_addr = {req.matrix_sel, req.row_index, req.col_index};

  // Handshakes.
  assign req.ready = (state_q == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign rsp.valid         = (state_q == S_OUT);
  assign rsp.control_index = CIDX_W'(k_q);
  assign rsp.control_value = u_q[k_q[UIW-1:0]];
  assign rsp.saturated     = sat_q;
  assign rsp.run_last      = (k_q == nu - CW'(1));

  // Configuration port.
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      CFG_STATES:   prdata = PDATA_W'(state_count_q);
      CFG_CONTROLS: prdata = PDATA_W'(control_count_q);
      CFG_MEAS:     prdata = PDATA_W'(meas_count_q);
      CFG_DIST:     prdata = PDATA_W'(dist_count_q);
      default:      prdata = '0;
    endcase
  end

  // Sequencer, configuration and vectors that reset clears.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      phase_q         <= P_E;
      seg_q           <= '0;
      i_q             <= '0;
      j_q             <= '0;
      k_q             <= '0;
      v1_q            <= 1'b0;
      v2_q            <= 1'b0;
      sat_q           <= 1'b0;
      state_count_q   <= STATES_W'(1);
      control_count_q <= CONTROL_W'(1);
      meas_count_q    <= MEAS_W'(1);
      dist_count_q    <= '0;
      xm_q            <= '{default: '0};
      dm_q            <= '{default: '0};
      sp_q            <= '{default: '0};
    end else begin
      // A product is issued whenever the sequencer steps through a segment.
      v1_q <= (state_q == S_ISSUE) && (j_q < seg_len);
      v2_q <= v1_q;

      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          CFG_STATES:   state_count_q   <= pwdata[STATES_W-1:0];
          CFG_CONTROLS: control_count_q <= pwdata[CONTROL_W-1:0];
          CFG_MEAS:     meas_count_q    <= pwdata[MEAS_W-1:0];
          CFG_DIST:     dist_count_q    <= pwdata[DIST_W-1:0];
          default:      dist_count_q    <= dist_count_q;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (req.req_type == REQ_SETPOINT && req.row_index < IDX_W'(MAX_CONTROLS)) begin
              sp_q[req.row_index[UIW-1:0]] <= req.data_value;
            end
            if (req.req_type == REQ_MEAS && req.sample_last) begin
              phase_q <= P_E;
              i_q     <= '0;
              sat_q   <= 1'b0;
              state_q <= S_LEAD;
            end
          end
        end
        S_LEAD: begin
          if (i_q >= rows) begin
            i_q <= '0;
            if (phase_q == P_X) begin
              for (int d = 0; d < MAX_DISTURBANCES; d++) begin
                if (d < int'(nd)) dm_q[d] <= dh_q[d];
              end
              k_q     <= '0;
              state_q <= S_OUT;
            end else begin
              phase_q <= phase_q + 4'd1;
            end
          end else begin
            seg_q   <= '0;
            j_q     <= '0;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (j_q < seg_len) begin
            j_q <= j_q + CW'(1);
          end else begin
            j_q <= '0;
            if (seg_q == SEG_LAST) state_q <= S_DRAIN;
            else                   seg_q   <= seg_q + 2'd1;
          end
        end
        S_DRAIN: begin
          if (!v1_q && !v2_q) state_q <= S_WB;
        end
        S_WB: begin
          if (sat_hi || sat_lo) sat_q <= 1'b1;
          if (phase_q == P_X) xm_q[i_q[XIW-1:0]] <= s32;
          i_q     <= i_q + CW'(1);
          state_q <= S_LEAD;
        end
        S_OUT: begin
          if (rsp.ready) begin
            if (k_q == nu - CW'(1)) state_q <= S_IDLE;
            else                    k_q     <= k_q + CW'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Coefficient RAM: write from requests, registered read for the MAC.
  always_ff @(posedge clk_i) begin
    if (accept && req.req_type == REQ_COEF && req.matrix_sel < SEL_W'(MAT_COUNT)) begin
      coef_mem[wr_addr] <= req.data_value;
    end
    coef_rd_q <= coef_mem[rd_addr];
  end

  // MAC pipeline: operand capture, multiply, then shift and accumulate.
  always_ff @(posedge clk_i) begin
    op_q   <= seg_op;
    prod_q <= coef_rd_q * op_q;
    if (state_q == S_LEAD) begin
      acc_q <= lead;
    end else if (v2_q) begin
      acc_q <= sub_mode ? acc_q - term : acc_q + term;
    end
  end

  // Measurement capture and write-back of working vectors.
  always_ff @(posedge clk_i) begin
    if (accept && req.req_type == REQ_MEAS && req.row_index < IDX_W'(MAX_MEASUREMENTS)) begin
      meas_q[req.row_index[MIW-1:0]] <= req.data_value;
    end
    if (state_q == S_WB) begin
      case (phase_q)
        P_E:     e_q[i_q[MIW-1:0]]   <= s32;
        P_XH:    xh_q[i_q[XIW-1:0]]  <= s32;
        P_DH:    dh_q[i_q[DIW-1:0]]  <= s32;
        P_PK:    pack_q[pk_wr_idx]   <= s32;
        P_CDD:   cdd_q[i_q[MIW-1:0]] <= s32;
        P_PU:    pack_q[pk_wr_idx]   <= s32;
        P_R:     r_q[i_q[NIW-1:0]]   <= s32;
        P_D:     dv_q[i_q[XIW-1:0]]  <= s32;
        P_U:     u_q[i_q[UIW-1:0]]   <= s32;
        default: u_q[i_q[UIW-1:0]]   <= u_q[i_q[UIW-1:0]];
      endcase
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the offset-free observer/controller.
// ----------------------------------------------------------------------------
// Request words are queued by the stimulus process and sent by a clocked
// driver with random gaps. Every accepted word also updates a bit-exact
// predictor of the block, which queues the control words that a completed
// sample must produce. A monitor checks each control word against the oldest
// prediction. Register settings change over the APB port between phases,
// only after the block has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import ofoc_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int CLK_PERIOD = 10;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 3000;

  // One request word as the driver presents it.
  typedef struct {
    logic [REQ_W-1:0]         kind;
    logic [SEL_W-1:0]         sel;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } request_t;

  // One control word as the block should deliver it.
  typedef struct {
    logic [CIDX_W-1:0]        index;
    logic signed [DATA_W-1:0] value;
    logic                     saturated;
    logic                     last;
  } control_word_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  ofoc_req_if rq ();
  ofoc_rsp_if rs ();

  offset_free_observer_controller u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (rq),
    .rsp     (rs),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  request_t      pending_words[$];
  control_word_t control_expected[$];

  // Shadow of the block's state and registers.
  logic signed [DATA_W-1:0] coef [MAT_COUNT][16][16];
  logic signed [DATA_W-1:0] x_pred [8];
  logic signed [DATA_W-1:0] d_pred [4];
  logic signed [DATA_W-1:0] meas_buf [8];
  logic signed [DATA_W-1:0] setpoint [4];
  logic [STATES_W-1:0]  reg_states;
  logic [CONTROL_W-1:0] reg_controls;
  logic [MEAS_W-1:0]    reg_meas;
  logic [DIST_W-1:0]    reg_dist;
  bit step_sat;

  int  error_count;
  int  sample_count;
  int  word_count;
  int  setting_count;
  int  cycle_count;
  int  send_gap;
  int  stall_left;
  int  hold_left;
  bit  no_idle;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Q16.16 product, rounded toward minus infinity.
  function automatic longint mul_q(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FRAC_W;
  endfunction

  // Saturate a 64-bit sum to 32 bits and note any clipping.
  function automatic logic signed [DATA_W-1:0] clip32(longint v);
    if (v > 64'sh7FFF_FFFF) begin
      step_sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      step_sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic int clamp_count(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // One control step: observer update, target selection, control law and
  // prediction. Queues the expected control words.
  task automatic predict_control_step();
    int nx, nu, ny, nd, n;
    longint acc;
    logic signed [DATA_W-1:0] err [8];
    logic signed [DATA_W-1:0] cdd [8];
    logic signed [DATA_W-1:0] xh [8];
    logic signed [DATA_W-1:0] dh [4];
    logic signed [DATA_W-1:0] pack [12];
    logic signed [DATA_W-1:0] tgt [12];
    logic signed [DATA_W-1:0] u [4];
    logic signed [DATA_W-1:0] diff;
    control_word_t w;
    nx = clamp_count(reg_states, 1, 8);
    nu = clamp_count(reg_controls, 1, 4);
    ny = clamp_count(reg_meas, 1, 8);
    nd = clamp_count(reg_dist, 0, 4);
    n = nx + nu;
    step_sat = 1'b0;
    for (int i = 0; i < 4; i++) dh[i] = '0;
    // Innovation.
    for (int i = 0; i < ny; i++) begin
      acc = meas_buf[i];
      for (int j = 0; j < nx; j++) acc -= mul_q(coef[MAT_C][i][j], x_pred[j]);
      for (int j = 0; j < nd; j++) acc -= mul_q(coef[MAT_CD][i][j], d_pred[j]);
      err[i] = clip32(acc);
    end
    // Corrected state and disturbance.
    for (int i = 0; i < nx; i++) begin
      acc = x_pred[i];
      for (int j = 0; j < ny; j++) acc += mul_q(coef[MAT_LX][i][j], err[j]);
      xh[i] = clip32(acc);
    end
    for (int i = 0; i < nd; i++) begin
      acc = d_pred[i];
      for (int j = 0; j < ny; j++) acc += mul_q(coef[MAT_LD][i][j], err[j]);
      dh[i] = clip32(acc);
    end
    // Target selector right-hand side.
    for (int i = 0; i < nx; i++) begin
      acc = 0;
      for (int j = 0; j < nd; j++) acc += mul_q(coef[MAT_BD][i][j], dh[j]);
      pack[i] = clip32(acc);
    end
    for (int i = 0; i < ny; i++) begin
      acc = 0;
      for (int j = 0; j < nd; j++) acc += mul_q(coef[MAT_CD][i][j], dh[j]);
      cdd[i] = clip32(acc);
    end
    for (int i = 0; i < nu; i++) begin
      acc = setpoint[i];
      for (int j = 0; j < ny; j++) acc -= mul_q(coef[MAT_H][i][j], cdd[j]);
      pack[nx + i] = clip32(acc);
    end
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int j = 0; j < n; j++) acc += mul_q(coef[MAT_GINV][i][j], pack[j]);
      tgt[i] = clip32(acc);
    end
    // Control law.
    for (int i = 0; i < nu; i++) begin
      acc = tgt[nx + i];
      for (int j = 0; j < nx; j++) begin
        diff = clip32(longint'(xh[j]) - longint'(tgt[j]));
        acc -= mul_q(coef[MAT_G][i][j], diff);
      end
      u[i] = clip32(acc);
    end
    // Next prediction.
    for (int i = 0; i < nx; i++) begin
      acc = 0;
      for (int j = 0; j < nx; j++) acc += mul_q(coef[MAT_A][i][j], xh[j]);
      for (int j = 0; j < nu; j++) acc += mul_q(coef[MAT_B][i][j], u[j]);
      for (int j = 0; j < nd; j++) acc += mul_q(coef[MAT_BD][i][j], dh[j]);
      x_pred[i] = clip32(acc);
    end
    for (int i = 0; i < nd; i++) d_pred[i] = dh[i];
    for (int i = 0; i < nu; i++) begin
      w.index = i[CIDX_W-1:0];
      w.value = u[i];
      w.saturated = step_sat;
      w.last = (i == nu - 1);
      control_expected.push_back(w);
    end
    sample_count++;
  endtask

  // Apply one accepted request word to the shadow state.
  task automatic apply_request(request_t r);
    if (r.kind == REQ_COEF) begin
      if (r.sel < MAT_COUNT) coef[r.sel][r.row][r.col] = r.value;
    end else if (r.kind == REQ_SETPOINT) begin
      if (r.row < 4) setpoint[r.row] = r.value;
    end else if (r.kind == REQ_MEAS) begin
      if (r.row < 8) meas_buf[r.row] = r.value;
      if (r.last) predict_control_step();
    end
  endtask

  // Gap length: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    if (no_idle || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Mostly small coefficients so the loop does not always saturate.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return $signed($urandom_range(0, 32'h8000)) - 32'sh4000;
    if (k < 8) return $signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
    return $urandom();
  endfunction

  function automatic request_t make_word(logic [REQ_W-1:0] kind, logic [SEL_W-1:0] sel,
                                         logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                         logic signed [DATA_W-1:0] value, logic last);
    request_t r;
    r.kind = kind;
    r.sel = sel;
    r.row = row;
    r.col = col;
    r.value = value;
    r.last = last;
    return r;
  endfunction

  // Request driver: holds a word until it is taken, then may idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rq.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (rq.valid && rq.ready) begin
        void'(pending_words.pop_front());
        send_gap = pick_gap();
      end
      if (rq.valid && !rq.ready) begin
        rq.valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        rq.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        rq.valid       <= 1'b1;
        rq.req_type    <= pending_words[0].kind;
        rq.matrix_sel  <= pending_words[0].sel;
        rq.row_index   <= pending_words[0].row;
        rq.col_index   <= pending_words[0].col;
        rq.data_value  <= pending_words[0].value;
        rq.sample_last <= pending_words[0].last;
      end else begin
        rq.valid <= 1'b0;
      end
    end
  end

  // Request monitor: every accepted word feeds the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && rq.valid && rq.ready) begin
      apply_request(make_word(rq.req_type, rq.matrix_sel, rq.row_index, rq.col_index,
                              rq.data_value, rq.sample_last));
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rs.ready <= 1'b0;
      stall_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      rs.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rs.ready <= 1'b0;
    end else begin
      rs.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Result monitor: compare each control word with the oldest prediction.
  always @(posedge clk_i) begin
    control_word_t w;
    if (rst_ni && rs.valid && rs.ready) begin
      word_count++;
      if (control_expected.size() == 0) begin
        $error("unexpected control word: index %0d value %0h", rs.control_index,
               rs.control_value);
        error_count++;
      end else begin
        w = control_expected.pop_front();
        if (rs.control_index !== w.index) begin
          $error("control_index: expected %0d, got %0d", w.index, rs.control_index);
          error_count++;
        end
        if (rs.control_value !== w.value) begin
          $error("control_value: expected %0h, got %0h", w.value, rs.control_value);
          error_count++;
        end
        if (rs.saturated !== w.saturated) begin
          $error("saturated: expected %0b, got %0b", w.saturated, rs.saturated);
          error_count++;
        end
        if (rs.run_last !== w.last) begin
          $error("run_last: expected %0b, got %0b", w.last, rs.run_last);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // APB register write; the shadow register changes at the access edge.
  task automatic write_register(logic [1:0] index, logic [PDATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (index)
      CFG_STATES:   reg_states   = value[STATES_W-1:0];
      CFG_CONTROLS: reg_controls = value[CONTROL_W-1:0];
      CFG_MEAS:     reg_meas     = value[MEAS_W-1:0];
      default:      reg_dist     = value[DIST_W-1:0];
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    setting_count++;
  endtask

  // Let the block drain completely. The check repeats after the pause so
  // that a step started by the last word is always waited out.
  task automatic wait_idle();
    do begin
      wait (pending_words.size() == 0 && control_expected.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
    end while (pending_words.size() != 0 || control_expected.size() != 0);
  endtask

  // Load a setting; upper bits are random since the block masks them.
  task automatic set_sizes(int nx, int nu, int ny, int nd);
    wait_idle();
    write_register(CFG_STATES,   PDATA_W'({$urandom() >> STATES_W, 4'(nx)}) );
    write_register(CFG_CONTROLS, PDATA_W'({$urandom() >> CONTROL_W, 3'(nu)}));
    write_register(CFG_MEAS,     PDATA_W'({$urandom() >> MEAS_W, 4'(ny)})   );
    write_register(CFG_DIST,     PDATA_W'({$urandom() >> DIST_W, 3'(nd)})   );
  endtask

  // Random traffic: mostly complete samples, some writes and noise.
  task automatic queue_random(int n_words);
    int sent, ny, k;
    sent = 0;
    while (sent < n_words) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        ny = clamp_count(reg_meas, 1, 8);
        for (int i = 0; i < ny; i++) begin
          pending_words.push_back(make_word(REQ_MEAS, SEL_W'($urandom()),
              IDX_W'(($urandom_range(0, 15) == 0) ? $urandom_range(8, 15)
                                                   : $urandom_range(0, 7)),
              IDX_W'($urandom()), $urandom_range(0, 3) == 0 ? $urandom() : pick_value(),
              i == ny - 1));
          sent++;
        end
      end else if (k < 8) begin
        pending_words.push_back(make_word(REQ_COEF, SEL_W'($urandom_range(0, 15)),
            IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 11)), pick_value(),
            1'($urandom())));
        sent++;
      end else if (k == 8) begin
        pending_words.push_back(make_word(REQ_SETPOINT, SEL_W'($urandom()),
            IDX_W'($urandom_range(0, 5)), IDX_W'($urandom()), pick_value(),
            1'($urandom())));
        sent++;
      end else begin
        // Noise: unknown requests and stray writes anywhere in the store.
        pending_words.push_back(make_word($urandom_range(0, 1) ? REQ_UNKNOWN : REQ_COEF,
            SEL_W'($urandom()), IDX_W'($urandom()), IDX_W'($urandom()), $urandom(),
            1'($urandom())));
        sent++;
      end
    end
  endtask

  // Stimulus.
  initial begin
    int rows [MAT_COUNT];
    int cols [MAT_COUNT];
    rows = '{8, 8, 8, 8, 8, 8, 4, 4, 12, 4};
    cols = '{8, 4, 8, 4, 4, 8, 8, 8, 12, 8};
    error_count = 0;
    sample_count = 0;
    word_count = 0;
    setting_count = 0;
    cycle_count = 0;
    hold_left = 0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rq.valid = 1'b0;
    rq.req_type = REQ_COEF;
    rq.matrix_sel = MAT_A;
    rq.row_index = '0;
    rq.col_index = '0;
    rq.data_value = '0;
    rq.sample_last = 1'b0;
    rs.ready = 1'b0;
    reg_states = 1;
    reg_controls = 1;
    reg_meas = 1;
    reg_dist = 0;
    step_sat = 1'b0;
    for (int i = 0; i < 8; i++) begin
      x_pred[i] = '0;
      meas_buf[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      d_pred[i] = '0;
      setpoint[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill every coefficient and measurement entry that any size can read.
    for (int m = 0; m < MAT_COUNT; m++)
      for (int r = 0; r < rows[m]; r++)
        for (int c = 0; c < cols[m]; c++)
          pending_words.push_back(make_word(REQ_COEF, SEL_W'(m), IDX_W'(r), IDX_W'(c),
                                            pick_value(), 1'b0));
    for (int i = 0; i < 8; i++)
      pending_words.push_back(make_word(REQ_MEAS, MAT_A, IDX_W'(i), '0, pick_value(), 1'b0));

    // Directed words at the reset sizes.
    pending_words.push_back(make_word(REQ_SETPOINT, MAT_A, '0, '0, 32'sh0001_0000, 1'b1));
    pending_words.push_back(make_word(REQ_MEAS, MAT_A, '0, '0, 32'sh7FFF_FFFF, 1'b1));
    pending_words.push_back(make_word(REQ_MEAS, MAT_A, '0, '0, 32'sh8000_0000, 1'b1));
    pending_words.push_back(make_word(REQ_MEAS, MAT_A, '0, '0, 32'sh0000_0000, 1'b1));
    // Bad matrix selectors leave the store alone.
    pending_words.push_back(make_word(REQ_COEF, 4'd10, '0, '0, 32'sh7FFF_FFFF, 1'b0));
    pending_words.push_back(make_word(REQ_COEF, 4'd15, 4'd15, 4'd15, 32'sh8000_0000, 1'b1));
    // Setpoint and measurement indexes past the end.
    pending_words.push_back(make_word(REQ_SETPOINT, MAT_A, 4'd15, '0, 32'sh7FFF_FFFF, 1'b0));
    pending_words.push_back(make_word(REQ_SETPOINT, MAT_A, 4'd4, '0, 32'sh8000_0000, 1'b0));
    pending_words.push_back(make_word(REQ_MEAS, MAT_A, 4'd15, '0, 32'sh7FFF_FFFF, 1'b1));
    pending_words.push_back(make_word(REQ_MEAS, MAT_A, 4'd8, '0, 32'sh8000_0000, 1'b0));
    // Unknown request, with the last flag set.
    pending_words.push_back(make_word(REQ_UNKNOWN, 4'd15, 4'd15, 4'd15, 32'shFFFF_FFFF,
                                      1'b1));
    // Extreme coefficient drives saturation.
    pending_words.push_back(make_word(REQ_COEF, MAT_GINV, 4'd1, 4'd1, 32'sh7FFF_FFFF, 1'b1));
    pending_words.push_back(make_word(REQ_SETPOINT, MAT_A, '0, '0, 32'sh8000_0000, 1'b0));
    pending_words.push_back(make_word(REQ_MEAS, MAT_A, '0, '0, 32'sh7FFF_FFFF, 1'b1));
    pending_words.push_back(make_word(REQ_COEF, MAT_GINV, 4'd1, 4'd1, 32'sh0000_4000, 1'b0));
    pending_words.push_back(make_word(REQ_MEAS, MAT_A, '0, '0, 32'sh0000_1000, 1'b1));

    // Largest sizes, with one long hold-off while words keep coming.
    set_sizes(8, 4, 8, 4);
    queue_random(10);
    @(negedge clk_i);
    hold_left = HOLD_CYCLES;
    queue_random(20);

    // Out-of-range register values get clamped.
    set_sizes(15, 7, 15, 7);
    no_idle = 1'b1;
    queue_random(25);
    set_sizes(0, 0, 0, 0);
    no_idle = 1'b0;
    queue_random(25);
    set_sizes(1, 1, 8, 0);
    queue_random(25);
    set_sizes(3, 2, 5, 1);
    queue_random(30);
    set_sizes(8, 4, 1, 0);
    queue_random(25);
    set_sizes($urandom_range(1, 8), $urandom_range(1, 4), $urandom_range(1, 8),
              $urandom_range(0, 4));
    no_idle = 1'($urandom_range(0, 1));
    queue_random(30);

    wait_idle();
    $display("Covered %0d control steps, %0d control words and %0d register writes",
             sample_count, word_count, setting_count);
    $display("across sizes from one state to eight states with up to four disturbances.");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
